// ----- hdl/lca_pkg.sv -----
package lca_pkg;

	localparam int NUM_LABELS = 1024;
	localparam int LABEL_W = 10;
	localparam int IDX_W = 10;
	localparam int SUM_W = 40;
	localparam int CNT_W = 31;
	localparam int QUO_W = 26;
	localparam int NUM_W = 57;
	localparam int PROD_W = 57;
	localparam logic [CNT_W-1:0] COUNT_LIMIT = 31'd1073741824;

	localparam logic MODE_ACC = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_SPACING_X = 3'd3;
	localparam logic [2:0] REG_SPACING_Y = 3'd4;
	localparam logic [2:0] REG_SPACING_Z = 3'd5;

	typedef struct packed {
		logic mode;
		logic [LABEL_W-1:0] label;
		logic [IDX_W-1:0] x_index;
		logic [IDX_W-1:0] y_index;
		logic [IDX_W-1:0] z_index;
	} item_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum_x;
		logic [SUM_W-1:0] sum_y;
		logic [SUM_W-1:0] sum_z;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [30:0] spacing_x;
		logic [30:0] spacing_y;
		logic [30:0] spacing_z;
	} cfg_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} queue_head_t;

endpackage

// ----- hdl/lca_if.sv -----
interface lca_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [9:0] label;
	logic [9:0] x_index;
	logic [9:0] y_index;
	logic [9:0] z_index;
	modport source (output valid, mode, label, x_index, y_index, z_index, input ready);
	modport sink (input valid, mode, label, x_index, y_index, z_index, output ready);
endinterface

interface lca_out_if;
	logic valid;
	logic ready;
	logic [9:0] label_out;
	logic signed [31:0] centroid_x;
	logic signed [31:0] centroid_y;
	logic signed [31:0] centroid_z;
	logic [30:0] voxel_count;
	logic present;
	modport source (output valid, label_out, centroid_x, centroid_y, centroid_z, voxel_count,
		present, input ready);
	modport sink (input valid, label_out, centroid_x, centroid_y, centroid_z, voxel_count,
		present, output ready);
endinterface

// ----- hdl/lca_front.sv -----
module lca_front (
	input logic clk,
	input logic arst_n,
	lca_in_if.sink in_ch,
	input logic clearing,
	input logic pop,
	output lca_pkg::queue_head_t head
);

	lca_pkg::item_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;
	logic push;
	lca_pkg::item_t in_item;

	assign in_ch.ready = (fill_q != 2'd2) && !clearing;
	assign push = in_ch.valid && in_ch.ready;

	always_comb begin
		in_item.mode = in_ch.mode;
		in_item.label = in_ch.label;
		in_item.x_index = in_ch.x_index;
		in_item.y_index = in_ch.y_index;
		in_item.z_index = in_ch.z_index;
	end

	assign head.valid = fill_q != 2'd0;
	assign head.item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- hdl/lca_back.sv -----
module lca_back (
	input logic clk,
	input logic arst_n,
	input lca_pkg::queue_head_t head,
	input lca_pkg::cfg_t cfg,
	output logic pop,
	output logic clearing,
	lca_out_if.source out_ch
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_MUL = 3'd4;
	localparam logic [2:0] ST_ADD = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	lca_pkg::entry_t mem [lca_pkg::NUM_LABELS];
	lca_pkg::entry_t rd_q;
	lca_pkg::entry_t wr_data;
	logic [lca_pkg::LABEL_W-1:0] wr_addr;
	logic wr_en;

	logic [2:0] state_q;
	logic [lca_pkg::LABEL_W-1:0] clr_addr_q;
	lca_pkg::item_t item_q;
	logic [1:0] axis_q;
	logic [31:0] rem_q;
	logic [lca_pkg::QUO_W-1:0] nlo_q;
	logic [lca_pkg::QUO_W-1:0] quo_q;
	logic [4:0] bit_q;
	logic [lca_pkg::PROD_W-1:0] prod_q;
	logic signed [31:0] cx_q, cy_q, cz_q;

	logic out_valid_q;
	logic [9:0] o_label_q;
	logic signed [31:0] o_cx_q, o_cy_q, o_cz_q;
	logic [30:0] o_cnt_q;
	logic o_present_q;

	logic [lca_pkg::SUM_W-1:0] sel_sum, next_sum;
	logic [30:0] sel_spc;
	logic signed [31:0] sel_org;
	logic [lca_pkg::NUM_W-1:0] num;
	logic [31:0] trial;
	logic ge;
	logic signed [42:0] csum;
	logic signed [31:0] csat;
	logic out_free;
	logic [1:0] next_axis;

	assign clearing = state_q == ST_CLEAR;
	assign pop = (state_q == ST_IDLE) && head.valid;
	assign out_free = !out_valid_q || out_ch.ready;
	assign next_axis = axis_q + 2'd1;

	function automatic logic [lca_pkg::NUM_W-1:0] div_num(input logic [lca_pkg::SUM_W-1:0] s,
		input logic [lca_pkg::CNT_W-1:0] c);
		logic [41:0] t;
		t = {1'b0, s, 1'b0} + {11'd0, c};
		return {t, 15'd0};
	endfunction

	always_comb begin
		case (state_q == ST_READ ? 2'd0 : next_axis)
			2'd0: sel_sum = rd_q.sum_x;
			2'd1: sel_sum = rd_q.sum_y;
			default: sel_sum = rd_q.sum_z;
		endcase
		case (axis_q)
			2'd0: begin
				sel_spc = cfg.spacing_x;
				sel_org = cfg.origin_x;
			end
			2'd1: begin
				sel_spc = cfg.spacing_y;
				sel_org = cfg.origin_y;
			end
			default: begin
				sel_spc = cfg.spacing_z;
				sel_org = cfg.origin_z;
			end
		endcase
		next_sum = sel_sum;
		num = div_num(next_sum, rd_q.cnt);
		trial = {rem_q[30:0], nlo_q[lca_pkg::QUO_W-1]};
		ge = trial >= {1'b0, rd_q.cnt};
		csum = {{11{sel_org[31]}}, sel_org} + {2'b00, prod_q[lca_pkg::PROD_W-1:16]};
		if (csum > 43'sd2147483647) begin
			csat = 32'sh7fffffff;
		end else if (csum < -43'sd2147483648) begin
			csat = 32'sh80000000;
		end else begin
			csat = csum[31:0];
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = item_q.label;
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = clr_addr_q;
		end else if (state_q == ST_READ) begin
			if (item_q.mode == lca_pkg::MODE_READ) begin
				wr_en = 1'b1;
			end else if (rd_q.cnt < lca_pkg::COUNT_LIMIT) begin
				wr_en = 1'b1;
				wr_data.sum_x = rd_q.sum_x + {30'd0, item_q.x_index};
				wr_data.sum_y = rd_q.sum_y + {30'd0, item_q.y_index};
				wr_data.sum_z = rd_q.sum_z + {30'd0, item_q.z_index};
				wr_data.cnt = rd_q.cnt + 31'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (pop) begin
			rd_q <= mem[head.item.label];
			item_q <= head.item;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_READ: begin
				rem_q <= {1'b0, num[lca_pkg::NUM_W-1:lca_pkg::QUO_W]};
				nlo_q <= num[lca_pkg::QUO_W-1:0];
				cx_q <= '0;
				cy_q <= '0;
				cz_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? trial - {1'b0, rd_q.cnt} : trial;
				nlo_q <= {nlo_q[lca_pkg::QUO_W-2:0], 1'b0};
				quo_q <= {quo_q[lca_pkg::QUO_W-2:0], ge};
			end
			ST_MUL: begin
				prod_q <= {26'd0, sel_spc} * {31'd0, quo_q};
			end
			ST_ADD: begin
				case (axis_q)
					2'd0: cx_q <= csat;
					2'd1: cy_q <= csat;
					default: cz_q <= csat;
				endcase
				rem_q <= {1'b0, num[lca_pkg::NUM_W-1:lca_pkg::QUO_W]};
				nlo_q <= num[lca_pkg::QUO_W-1:0];
			end
			default: begin
			end
		endcase
		if (state_q == ST_OUT && out_free) begin
			o_label_q <= item_q.label;
			o_cx_q <= cx_q;
			o_cy_q <= cy_q;
			o_cz_q <= cz_q;
			o_cnt_q <= rd_q.cnt;
			o_present_q <= rd_q.cnt != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			axis_q <= 2'd0;
			bit_q <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (&clr_addr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					axis_q <= 2'd0;
					bit_q <= 5'd0;
					if (item_q.mode == lca_pkg::MODE_ACC) begin
						state_q <= ST_IDLE;
					end else if (rd_q.cnt == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					bit_q <= bit_q + 5'd1;
					if (bit_q == 5'(lca_pkg::QUO_W - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: begin
					bit_q <= 5'd0;
					axis_q <= next_axis;
					state_q <= (axis_q == 2'd2) ? ST_OUT : ST_DIV;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.label_out = o_label_q;
	assign out_ch.centroid_x = o_cx_q;
	assign out_ch.centroid_y = o_cy_q;
	assign out_ch.centroid_z = o_cz_q;
	assign out_ch.voxel_count = o_cnt_q;
	assign out_ch.present = o_present_q;

endmodule

// ----- hdl/label_centroid_accumulator.sv -----
// per-label centroid accumulator
// in_ch: mode 0 adds one voxel (x, y, z index) to its label, none once its count reaches 2^30, gives no item
// mode 1 reads out one label: one item on out_ch with the centroid
// origin + spacing * (mean index + 0.5) per axis, signed Q16.16 saturated,
// the voxel count and a present flag, then clears that label
// a two-entry queue sits between the input side and the table engine
// accumulate: table read, then read-modify-write, per item
// readout uses a shared 1 bit per cycle divider
// and one 31x26 multiplier, reused for the three axes
// after reset the label tables are swept to zero with in_ch.ready low
// registers are set to origin 0 and spacing 1.0 at reset; apb writes take effect
// at once and are meant for idle periods only
// out_ch has an output register: when the receiver stalls, one result waits there,
// queued items are still taken and accumulates keep going until the next readout
module label_centroid_accumulator (
	input logic clk,
	input logic arst_n,
	lca_in_if.sink in_ch,
	lca_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	lca_pkg::cfg_t cfg_q;
	lca_pkg::queue_head_t head;
	logic pop;
	logic clearing;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.spacing_x <= 31'd65536;
			cfg_q.spacing_y <= 31'd65536;
			cfg_q.spacing_z <= 31'd65536;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				lca_pkg::REG_ORIGIN_X: cfg_q.origin_x <= pwdata;
				lca_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= pwdata;
				lca_pkg::REG_ORIGIN_Z: cfg_q.origin_z <= pwdata;
				lca_pkg::REG_SPACING_X: cfg_q.spacing_x <= pwdata[30:0];
				lca_pkg::REG_SPACING_Y: cfg_q.spacing_y <= pwdata[30:0];
				lca_pkg::REG_SPACING_Z: cfg_q.spacing_z <= pwdata[30:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			lca_pkg::REG_ORIGIN_X: prdata = cfg_q.origin_x;
			lca_pkg::REG_ORIGIN_Y: prdata = cfg_q.origin_y;
			lca_pkg::REG_ORIGIN_Z: prdata = cfg_q.origin_z;
			lca_pkg::REG_SPACING_X: prdata = {1'b0, cfg_q.spacing_x};
			lca_pkg::REG_SPACING_Y: prdata = {1'b0, cfg_q.spacing_y};
			lca_pkg::REG_SPACING_Z: prdata = {1'b0, cfg_q.spacing_z};
			default: prdata = '0;
		endcase
	end

	lca_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.clearing(clearing),
		.pop(pop),
		.head(head)
	);

	lca_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.cfg(cfg_q),
		.pop(pop),
		.clearing(clearing),
		.out_ch(out_ch)
	);

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

	typedef struct {
		logic [lca_pkg::LABEL_W-1:0] label;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic [lca_pkg::CNT_W-1:0] count;
		logic present;
	} centroid_t;

	typedef struct {
		lca_pkg::item_t it;
		bit typed;
		centroid_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	lca_in_if in_ch ();
	lca_out_if out_ch ();

	label_centroid_accumulator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [lca_pkg::SUM_W-1:0] sum_x [lca_pkg::NUM_LABELS];
	logic [lca_pkg::SUM_W-1:0] sum_y [lca_pkg::NUM_LABELS];
	logic [lca_pkg::SUM_W-1:0] sum_z [lca_pkg::NUM_LABELS];
	logic [lca_pkg::CNT_W-1:0] voxels [lca_pkg::NUM_LABELS];
	lca_pkg::cfg_t geom;
	centroid_t centroid_q [$];
	row_t rows [$];
	int errors = 0;
	int hold_cycles = 0;
	bit calm = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic logic [31:0] centroid_axis(input logic [lca_pkg::SUM_W-1:0] s,
		input logic [lca_pkg::CNT_W-1:0] n, input logic [31:0] org, input logic [30:0] spc);
		logic [63:0] num;
		logic [63:0] m;
		logic [63:0] p;
		longint c;
		num = ({24'd0, s} * 64'd2 + {33'd0, n}) << 15;
		m = num / {33'd0, n};
		p = ({33'd0, spc} * m) >> 16;
		c = longint'($signed(org)) + longint'(p);
		if (c > 64'sd2147483647)
			c = 64'sd2147483647;
		if (c < -64'sd2147483648)
			c = -64'sd2147483648;
		return c[31:0];
	endfunction

	task automatic add_row(input lca_pkg::item_t it, input bit typed, input centroid_t want);
		row_t r;
		r.it = it;
		r.typed = typed;
		r.want = want;
		rows.insert(rows.size(), r);
	endtask

	task automatic apply_item(input lca_pkg::item_t it);
		centroid_t r;
		if (it.mode == lca_pkg::MODE_ACC) begin
			if (voxels[it.label] < lca_pkg::COUNT_LIMIT) begin
				sum_x[it.label] += {30'd0, it.x_index};
				sum_y[it.label] += {30'd0, it.y_index};
				sum_z[it.label] += {30'd0, it.z_index};
				voxels[it.label] += 31'd1;
			end
		end else begin
			r = '{it.label, 0, 0, 0, 0, 0};
			if (voxels[it.label] != 0) begin
				r.cx = centroid_axis(sum_x[it.label], voxels[it.label], geom.origin_x,
					geom.spacing_x);
				r.cy = centroid_axis(sum_y[it.label], voxels[it.label], geom.origin_y,
					geom.spacing_y);
				r.cz = centroid_axis(sum_z[it.label], voxels[it.label], geom.origin_z,
					geom.spacing_z);
				r.count = voxels[it.label];
				r.present = 1;
			end
			sum_x[it.label] = 0;
			sum_y[it.label] = 0;
			sum_z[it.label] = 0;
			voxels[it.label] = 0;
			centroid_q.insert(centroid_q.size(), r);
		end
	endtask

	task automatic send_item(input lca_pkg::item_t it);
		in_ch.valid = 1;
		in_ch.mode = it.mode;
		in_ch.label = it.label;
		in_ch.x_index = it.x_index;
		in_ch.y_index = it.y_index;
		in_ch.z_index = it.z_index;
		do
			@(posedge clk);
		while (!in_ch.ready);
		apply_item(it);
		@(negedge clk);
	endtask

	task automatic idle_input(input int n);
		repeat (n) begin
			in_ch.valid = 0;
			in_ch.mode = 1'($urandom);
			in_ch.label = 10'($urandom);
			in_ch.x_index = 10'($urandom);
			in_ch.y_index = 10'($urandom);
			in_ch.z_index = 10'($urandom);
			@(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		case (idx)
			lca_pkg::REG_ORIGIN_X: geom.origin_x = value;
			lca_pkg::REG_ORIGIN_Y: geom.origin_y = value;
			lca_pkg::REG_ORIGIN_Z: geom.origin_z = value;
			lca_pkg::REG_SPACING_X: geom.spacing_x = value[30:0];
			lca_pkg::REG_SPACING_Y: geom.spacing_y = value[30:0];
			lca_pkg::REG_SPACING_Z: geom.spacing_z = value[30:0];
			default: ;
		endcase
	endtask

	task automatic drain;
		in_ch.valid = 0;
		wait (centroid_q.size() == 0);
		repeat (100) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_geometry(input logic [31:0] ox, input logic [31:0] oy,
		input logic [31:0] oz, input logic [31:0] sx, input logic [31:0] sy,
		input logic [31:0] sz);
		drain();
		write_reg(lca_pkg::REG_ORIGIN_X, ox);
		write_reg(lca_pkg::REG_ORIGIN_Y, oy);
		write_reg(lca_pkg::REG_ORIGIN_Z, oz);
		write_reg(lca_pkg::REG_SPACING_X, sx);
		write_reg(lca_pkg::REG_SPACING_Y, sy);
		write_reg(lca_pkg::REG_SPACING_Z, sz);
	endtask

	function automatic lca_pkg::item_t random_item(input int read_pct);
		lca_pkg::item_t it;
		it.mode = ($urandom_range(0, 99) < read_pct) ? lca_pkg::MODE_READ : lca_pkg::MODE_ACC;
		it.label = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 15)) : 10'($urandom);
		it.x_index = 10'($urandom);
		it.y_index = 10'($urandom);
		it.z_index = 10'($urandom);
		return it;
	endfunction

	always @(posedge clk) begin
		centroid_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (centroid_q.size() == 0) begin
				report("unexpected item", out_ch.label_out, 0);
			end else begin
				w = centroid_q.pop_front();
				if (out_ch.label_out !== w.label)
					report("label_out", out_ch.label_out, w.label);
				if (out_ch.centroid_x !== w.cx)
					report("centroid_x", out_ch.centroid_x, w.cx);
				if (out_ch.centroid_y !== w.cy)
					report("centroid_y", out_ch.centroid_y, w.cy);
				if (out_ch.centroid_z !== w.cz)
					report("centroid_z", out_ch.centroid_z, w.cz);
				if (out_ch.voxel_count !== w.count)
					report("voxel_count", out_ch.voxel_count, w.count);
				if (out_ch.present !== w.present)
					report("present", out_ch.present, w.present);
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready = 0;
				hold_cycles--;
			end else begin
				if (!calm && stall == 0 && $urandom_range(0, 9) == 0)
					stall = $urandom_range(1, 11);
				if (stall > 0) begin
					out_ch.ready = 0;
					stall--;
				end else begin
					out_ch.ready = 1;
				end
			end
		end
	end

	initial begin
		centroid_t none;
		lca_pkg::item_t it;
		none = '{0, 0, 0, 0, 0, 0};
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_ch.valid = 0;
		in_ch.mode = 0;
		in_ch.label = 0;
		in_ch.x_index = 0;
		in_ch.y_index = 0;
		in_ch.z_index = 0;
		for (int i = 0; i < lca_pkg::NUM_LABELS; i++) begin
			sum_x[i] = 0;
			sum_y[i] = 0;
			sum_z[i] = 0;
			voxels[i] = 0;
		end
		geom = '{0, 0, 0, 31'd65536, 31'd65536, 31'd65536};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		add_row('{lca_pkg::MODE_READ, 10'd0, 10'd0, 10'd0, 10'd0}, 1, none);
		add_row('{lca_pkg::MODE_READ, 10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1,
			'{10'd1023, 0, 0, 0, 0, 0});
		add_row('{lca_pkg::MODE_ACC, 10'd5, 10'd0, 10'd0, 10'd0}, 0, none);
		add_row('{lca_pkg::MODE_READ, 10'd5, 10'd0, 10'd0, 10'd0}, 1,
			'{10'd5, 32'd32768, 32'd32768, 32'd32768, 31'd1, 1'b1});
		add_row('{lca_pkg::MODE_ACC, 10'd1023, 10'd1023, 10'd1023, 10'd1023}, 0, none);
		add_row('{lca_pkg::MODE_READ, 10'd1023, 10'd0, 10'd0, 10'd0}, 1,
			'{10'd1023, 32'd67076096, 32'd67076096, 32'd67076096, 31'd1, 1'b1});
		add_row('{lca_pkg::MODE_READ, 10'd1023, 10'd0, 10'd0, 10'd0}, 1,
			'{10'd1023, 0, 0, 0, 0, 0});
		add_row('{lca_pkg::MODE_ACC, 10'd7, 10'd1023, 10'd0, 10'd512}, 0, none);
		add_row('{lca_pkg::MODE_ACC, 10'd7, 10'd0, 10'd1023, 10'd1}, 0, none);
		add_row('{lca_pkg::MODE_ACC, 10'd7, 10'd5, 10'd6, 10'd7}, 0, none);
		add_row('{lca_pkg::MODE_ACC, 10'd7, 10'd1023, 10'd1023, 10'd0}, 0, none);
		add_row('{lca_pkg::MODE_READ, 10'd7, 10'd0, 10'd0, 10'd0}, 0, none);
		add_row('{lca_pkg::MODE_ACC, 10'd512, 10'd341, 10'd682, 10'd3}, 0, none);
		add_row('{lca_pkg::MODE_ACC, 10'd512, 10'd340, 10'd681, 10'd2}, 0, none);
		add_row('{lca_pkg::MODE_ACC, 10'd300, 10'd1, 10'd2, 10'd3}, 0, none);
		add_row('{lca_pkg::MODE_READ, 10'd512, 10'd1023, 10'd1023, 10'd1023}, 0, none);
		add_row('{lca_pkg::MODE_READ, 10'd300, 10'd0, 10'd0, 10'd0}, 0, none);
		add_row('{lca_pkg::MODE_READ, 10'd300, 10'd0, 10'd0, 10'd0}, 0, none);
		foreach (rows[i]) begin
			send_item(rows[i].it);
			if (rows[i].typed) begin
				centroid_q[centroid_q.size() - 1] = rows[i].want;
			end
		end

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: ;
				1: set_geometry(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
					32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
				2: set_geometry(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1);
				3: set_geometry($urandom, $urandom, $urandom, 0, 0, 0);
				4: set_geometry(32'hfff00000, 32'h00100000, 32'hffff8000,
					$urandom_range(1, 2147483647), $urandom_range(1, 2147483647),
					$urandom_range(1, 2147483647));
				default: set_geometry($urandom, $urandom, $urandom,
					$urandom_range(1, 2147483647), $urandom_range(1, 2147483647),
					$urandom_range(1, 2147483647));
			endcase
			if (phase == 2)
				hold_cycles = 1500;
			if (phase == 6)
				calm = 1;
			for (int k = 0; k < 125; k++) begin
				if (!calm && $urandom_range(0, 7) == 0)
					idle_input($urandom_range(1, 11));
				if (phase == 4 && k == 60) begin
					in_ch.valid = 0;
					wait (centroid_q.size() == 0);
					@(negedge clk);
				end
				it = random_item(phase == 2 ? 40 : 12);
				send_item(it);
			end
		end
		in_ch.valid = 0;
		wait (centroid_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
